FILE: src/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and arithmetic helpers for the LED symbol sequencer.
// ----------------------------------------------------------------------------
package lss_pkg;

   // default number of ring entries, one of them always kept free
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // duration code that holds a symbol lit until the next enqueue and empties the ring
   localparam logic [7:0] HOLD_FOREVER = 8'd255;
   localparam logic [7:0] FULL_SCALE   = 8'd255;
   localparam logic [7:0] TICK_MAX     = 8'd255;

   // command codes carried on tuser
   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_ENQUEUE   = 2'd1,
      CMD_CLEAR_ENQ = 2'd2
   } cmd_type;

   // one symbol, intensity in the lowest byte
   typedef struct packed {
      logic [7:0] pause;
      logic [7:0] duration;
      logic [7:0] color;
      logic [7:0] intensity;
   } sym_type;

   // one result word
   typedef struct packed {
      logic       refill_request;
      logic       accepted;
      logic [7:0] drive_b;
      logic [7:0] drive_a;
      logic       led_enable;
   } rsp_type;

   // x / 255 for x up to 255 * 255, by reciprocal with correction
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

endpackage

FILE: src/led_symbol_sequencer.sv
// ----------------------------------------------------------------------------
// led_symbol_sequencer
// Queues LED symbols in a ring and plays them out on decisecond ticks,
// producing two PWM compare values and an LED enable for every word.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                    | tuser
//  req_     | in  | intensity, color, duration, pause        | command
//  rsp_     | out | led_enable, drive_a, drive_b, accepted,  | -
//           |     | refill_request                           |
//
// One word per cycle while rsp_tready stays high; each word passes through
// the input register, then the result register. The path between them
// is two parallel 8x8 multiplies, each with a divide by 255, on the symbol taken.
// Reset empties the ring and turns the LED off; ring contents are not cleared.
// A stall on rsp_tready holds the result; the input register then fills and
// req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module led_symbol_sequencer
   import lss_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // intensity[7:0] color[15:8] duration[23:16] pause[31:24]
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // led_enable[0] drive_a[8:1] drive_b[16:9]
                                   // accepted[17] refill_request[18] zero[23:19]
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // input register
   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   sym_type    in_sym_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // sequencer state
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             show_ff, show_in;
   sym_type          shown_ff, shown_in;
   logic             pause_ff, pause_in;
   logic [7:0]       elapsed_ff, elapsed_in;
   logic             led_en_ff, led_en_in;
   logic [7:0]       led_a_ff, led_a_in;
   logic [7:0]       led_b_ff, led_b_in;

   // ring memory and its registered head read
   sym_type          ring_mem [QUEUE_DEPTH];
   sym_type          head_ff;
   logic             mem_we;
   logic [PTR_W-1:0] mem_waddr;

   logic    process;
   logic    do_take;
   sym_type head;
   logic [7:0]  inv;
   logic [15:0] prod_a;
   logic [15:0] prod_b;
   logic [7:0]  drv_a;
   logic [7:0]  drv_b;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // handshake
   assign process    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || process;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_sym_ff <= sym_type'(req_tdata);
      end
   end

   // led drive from the symbol being taken
   assign inv    = FULL_SCALE - head.intensity;
   assign prod_a = inv * head.color;
   assign prod_b = inv * (FULL_SCALE - head.color);
   assign drv_a  = head.color - div255(prod_a);
   assign drv_b  = head.color + div255(prod_b);

   // step logic
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      show_in    = show_ff;
      shown_in   = shown_ff;
      pause_in   = pause_ff;
      elapsed_in = elapsed_ff;
      led_en_in  = led_en_ff;
      led_a_in   = led_a_ff;
      led_b_in   = led_b_ff;
      mem_we     = 1'b0;
      mem_waddr  = wr_ptr_ff;
      do_take    = 1'b0;
      head       = in_sym_ff;
      rsp_data_in.accepted       = 1'b0;
      rsp_data_in.refill_request = 1'b0;

      if (process) begin
         case (in_cmd_ff)
            CMD_ENQUEUE, CMD_CLEAR_ENQ: begin
               if (in_cmd_ff == CMD_CLEAR_ENQ) begin
                  wr_ptr_in = '0;
                  rd_ptr_in = '0;
                  show_in   = 1'b0;
               end
               if (ring_next(wr_ptr_in) != rd_ptr_in) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ptr_in;
                  wr_ptr_in = ring_next(wr_ptr_in);
                  rsp_data_in.accepted = 1'b1;
                  // ring was empty while idle: the new symbol starts at once
                  if (!show_in && ring_next(rd_ptr_in) == wr_ptr_in) begin
                     do_take = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (show_ff) begin
                  head = head_ff;
                  if (elapsed_ff != TICK_MAX) begin
                     elapsed_in = elapsed_ff + 8'd1;
                  end
                  if (!pause_ff && shown_ff.duration != 8'd0) begin
                     if (elapsed_in >= shown_ff.duration) begin
                        if (shown_ff.pause != 8'd0) begin
                           led_en_in  = 1'b0;
                           pause_in   = 1'b1;
                           elapsed_in = 8'd0;
                        end else begin
                           do_take = 1'b1;
                        end
                     end
                  end else if (elapsed_in >= shown_ff.pause) begin
                     do_take = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         // take the head symbol, or go dark and request a refill when the ring is dry
         if (do_take) begin
            if (rd_ptr_in != wr_ptr_in) begin
               if (head.intensity != 8'd0) begin
                  led_en_in = 1'b1;
                  led_a_in  = drv_a;
                  led_b_in  = drv_b;
               end else begin
                  led_en_in = 1'b0;
               end
               if (head.duration != HOLD_FOREVER) begin
                  rd_ptr_in  = ring_next(rd_ptr_in);
                  shown_in   = head;
                  show_in    = 1'b1;
                  pause_in   = 1'b0;
                  elapsed_in = 8'd0;
               end else begin
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
                  show_in   = 1'b0;
               end
            end else begin
               show_in   = 1'b0;
               led_en_in = 1'b0;
               rsp_data_in.refill_request = 1'b1;
            end
         end
      end

      rsp_data_in.led_enable = led_en_in;
      rsp_data_in.drive_a    = led_a_in;
      rsp_data_in.drive_b    = led_b_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         show_ff    <= 1'b0;
         shown_ff   <= '0;
         pause_ff   <= 1'b0;
         elapsed_ff <= 8'd0;
         led_en_ff  <= 1'b0;
         led_a_ff   <= 8'd0;
         led_b_ff   <= 8'd0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         show_ff    <= show_in;
         shown_ff   <= shown_in;
         pause_ff   <= pause_in;
         elapsed_ff <= elapsed_in;
         led_en_ff  <= led_en_in;
         led_a_ff   <= led_a_in;
         led_b_ff   <= led_b_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ring write, head read at the next read pointer with write bypass
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= in_sym_ff;
      end
      if (mem_we && mem_waddr == rd_ptr_in) begin
         head_ff <= in_sym_ff;
      end else begin
         head_ff <= ring_mem[rd_ptr_in];
      end
   end

   // checks
   a_idle_ring_empty: assert property (@(posedge clock) disable iff (reset)
      !show_ff |-> rd_ptr_ff == wr_ptr_ff)
      else $error("ring not empty while no symbol is on show");

   a_pause_dark: assert property (@(posedge clock) disable iff (reset)
      show_ff && pause_ff |-> !led_en_ff)
      else $error("led lit during pause");

   a_refill_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.refill_request |-> !rsp_data_ff.led_enable &&
      !rsp_data_ff.accepted)
      else $error("refill request with led lit or symbol accepted");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff <= PTR_LAST && rd_ptr_ff <= PTR_LAST)
      else $error("ring pointer out of range");

   a_accept_enqueue: assert property (@(posedge clock) disable iff (reset)
      process && in_cmd_ff == CMD_TICK |=> !rsp_data_ff.accepted)
      else $error("tick reported as accepted");

endmodule
